// File: hdl/clut_texture_pixel_decode_assert.svh
// Assertion helpers used by the decoder's issue module (ctpd_issue).
// Each expects clk and rst_n in scope.
`ifndef CLUT_TEXTURE_PIXEL_DECODE_ASSERT_SVH
`define CLUT_TEXTURE_PIXEL_DECODE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ctpd_pkg.sv
`default_nettype none

package ctpd_pkg;

    localparam int CTPD_PALETTE_DEPTH = 256;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic CFG_INDEX_MODE     = 1'b0;
    localparam logic CFG_PALETTE_FORMAT = 1'b1;

    localparam logic [1:0] MODE_DIRECT  = 2'd0;
    localparam logic [1:0] MODE_NIBBLE  = 2'd1;
    localparam logic [1:0] MODE_SWIZZLE = 2'd2;

    localparam logic [1:0] FMT_NONE   = 2'd0;
    localparam logic [1:0] FMT_A1BGR5 = 2'd1;
    localparam logic [1:0] FMT_XBGR8  = 2'd2;
    localparam logic [1:0] FMT_ABGR8  = 2'd3;

    localparam logic [1:0] INDEX_MODE_RESET     = MODE_SWIZZLE;
    localparam logic [1:0] PALETTE_FORMAT_RESET = FMT_ABGR8;

    // floor(c * 255 / 31) for each 5-bit channel value
    localparam logic [7:0] EXPAND5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // One palette access issued toward the memory
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [7:0]  idx;
        logic [31:0] wdata;
        logic        last;
        logic [31:0] pixel;
    } ctpd_req_t;

    // Looked-up entry waiting for expansion
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [31:0] entry;
        logic [31:0] pixel;
    } ctpd_stage_t;

endpackage

`default_nettype wire

// File: hdl/ctpd_if.sv
`default_nettype none

interface ctpd_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  palette_index;
    logic [31:0] palette_word;
    logic [31:0] pixel_word;

    modport source (
        output valid, command, palette_index, palette_word, pixel_word,
        input  ready
    );
    modport sink (
        input  valid, command, palette_index, palette_word, pixel_word,
        output ready
    );
endinterface

interface ctpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;

    modport source (
        output valid, red, green, blue, alpha, last,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, alpha, last,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/ctpd_issue.sv
`default_nettype none
`include "clut_texture_pixel_decode_assert.svh"

module ctpd_issue
    import ctpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    ctpd_in_if.sink         in,
    input  wire logic [1:0] index_mode,
    input  wire logic       slot_free,
    output ctpd_req_t       req
);

    logic        pend_reg;
    logic        pend_next;
    logic [3:0]  pend_hi_reg;
    logic [31:0] pend_pixel_reg;
    logic        accept;
    logic [7:0]  ibyte;
    logic        split;

    assign in.ready = slot_free && !pend_reg;
    assign accept   = in.valid && in.ready;
    assign ibyte    = in.pixel_word[7:0];
    assign split    = accept && (in.command == CMD_DECODE) && (index_mode == MODE_NIBBLE);

    always_comb
    begin
        req       = '0;
        pend_next = pend_reg;
        if (pend_reg)
        begin
            // second pixel of a nibble pair
            req.rd    = slot_free;
            req.idx   = {4'b0000, pend_hi_reg};
            req.last  = 1'b1;
            req.pixel = pend_pixel_reg;
            pend_next = !slot_free;
        end
        else if (accept)
        begin
            if (in.command == CMD_WRITE)
            begin
                req.wr    = 1'b1;
                req.idx   = in.palette_index;
                req.wdata = in.palette_word;
            end
            else
            begin
                req.rd    = 1'b1;
                req.pixel = in.pixel_word;
                req.last  = 1'b1;
                case (index_mode)
                    MODE_NIBBLE:
                    begin
                        req.idx   = {4'b0000, ibyte[3:0]};
                        req.last  = 1'b0;
                        pend_next = 1'b1;
                    end
                    MODE_SWIZZLE: req.idx = {ibyte[7:5], ibyte[3], ibyte[4], ibyte[2:0]};
                    default:      req.idx = ibyte;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (split)
        begin
            pend_hi_reg    <= ibyte[7:4];
            pend_pixel_reg <= in.pixel_word;
        end
    end

    `CTPD_ASSERT_SAME(a_pend_blocks_input, pend_reg, !in.ready, "input taken during nibble pair")
    `CTPD_ASSERT_NEXT(a_split_sets_pend, split, pend_reg, "nibble pair not held for second beat")
    `CTPD_ASSERT_NEXT(a_pend_retires, pend_reg && slot_free, !pend_reg, "second nibble not retired")
    `CTPD_ASSERT_SAME(a_read_has_slot, req.rd, slot_free && !req.wr, "read issued into full stage")

endmodule

`default_nettype wire

// File: hdl/ctpd_palette.sv
`default_nettype none

module ctpd_palette
    import ctpd_pkg::*;
#(
    parameter int PALETTE_DEPTH = CTPD_PALETTE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ctpd_req_t req,
    input  wire logic      take,
    output logic           slot_free,
    output ctpd_stage_t    stage
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

    logic [31:0]   mem [PALETTE_DEPTH];
    logic [AW-1:0] addr;
    logic          in_range;
    logic [31:0]   rd_data_reg;
    logic          s1_valid_reg;
    logic          s1_last_reg;
    logic          s1_oor_reg;
    logic [31:0]   s1_pixel_reg;

    assign addr      = req.idx[AW-1:0];
    assign in_range  = {1'b0, req.idx} < DEPTH_W;
    assign slot_free = !s1_valid_reg || take;

    always_ff @(posedge clk)
    begin
        if (req.wr && in_range)
        begin
            mem[addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rd_data_reg  <= mem[addr];
            s1_last_reg  <= req.last;
            s1_oor_reg   <= !in_range;
            s1_pixel_reg <= req.pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.rd)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // entries beyond the palette read as zero
    assign stage.valid = s1_valid_reg;
    assign stage.last  = s1_last_reg;
    assign stage.entry = s1_oor_reg ? 32'h0000_0000 : rd_data_reg;
    assign stage.pixel = s1_pixel_reg;

endmodule

`default_nettype wire

// File: hdl/ctpd_expand.sv
`default_nettype none

module ctpd_expand
    import ctpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctpd_stage_t stage,
    input  wire logic [1:0]  palette_format,
    output logic             take,
    ctpd_out_if.source       out
);

    logic        out_valid_reg;
    logic [31:0] rgba_reg;
    logic        last_reg;
    logic [31:0] rgba;
    logic [31:0] e;

    assign e    = stage.entry;
    assign take = stage.valid && (!out_valid_reg || out.ready);

    always_comb
    begin
        unique case (palette_format)
            FMT_NONE:   rgba = stage.pixel;
            FMT_A1BGR5: rgba = {e[15] ? 8'hFF : 8'h00, EXPAND5_LUT[e[14:10]],
                                EXPAND5_LUT[e[9:5]], EXPAND5_LUT[e[4:0]]};
            FMT_XBGR8:  rgba = {8'hFF, e[23:0]};
            FMT_ABGR8:  rgba = e;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rgba_reg <= rgba;
            last_reg <= stage.last;
        end
    end

    assign out.valid = out_valid_reg;
    assign out.red   = rgba_reg[7:0];
    assign out.green = rgba_reg[15:8];
    assign out.blue  = rgba_reg[23:16];
    assign out.alpha = rgba_reg[31:24];
    assign out.last  = last_reg;

endmodule

`default_nettype wire

// File: hdl/clut_texture_pixel_decode.sv
// Palette texture decoder.
// Input channel "in": a beat with command write stores palette_word at
// palette_index and produces nothing; a beat with command decode takes
// byte 0 of pixel_word as index and produces RGBA beats on channel "out".
// Direct and swizzled modes give one beat (last set); 4-bit mode gives two,
// low nibble first, the second with last set.
// A decode beat passes the palette read register, then the output register,
// before it is shown on "out".
// One input beat per cycle in direct and swizzled modes while "out" does not
// stall; in 4-bit mode no new input beat is taken until the second nibble is
// issued, as the single palette read port serves one lookup per cycle.
// A write is visible to any decode beat accepted after it.
// When "out" stalls, the output register holds, the read stage holds behind
// it, and in.ready drops once both are full; nothing is dropped.
// Reset clears the pipeline valids and loads index_mode = 2 and
// palette_format = 3; palette contents stay undefined until written.
// Configuration: cfg_we with cfg_index (0 index_mode, 1 palette_format) and
// cfg_data; write only while the block is idle.
`default_nettype none

module clut_texture_pixel_decode
    import ctpd_pkg::*;
#(
    parameter int PALETTE_DEPTH = CTPD_PALETTE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    ctpd_in_if.sink         in,
    ctpd_out_if.source      out,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [1:0] cfg_data
);

    logic [1:0]  index_mode_reg;
    logic [1:0]  palette_format_reg;
    ctpd_req_t   req;
    ctpd_stage_t stage;
    logic        slot_free;
    logic        take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_mode_reg     <= INDEX_MODE_RESET;
            palette_format_reg <= PALETTE_FORMAT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INDEX_MODE:     index_mode_reg     <= cfg_data;
                CFG_PALETTE_FORMAT: palette_format_reg <= cfg_data;
                default:            index_mode_reg     <= index_mode_reg;
            endcase
        end
    end

    ctpd_issue u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in         (in),
        .index_mode (index_mode_reg),
        .slot_free  (slot_free),
        .req        (req)
    );

    ctpd_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .take      (take),
        .slot_free (slot_free),
        .stage     (stage)
    );

    ctpd_expand u_expand (
        .clk            (clk),
        .rst_n          (rst_n),
        .stage          (stage),
        .palette_format (palette_format_reg),
        .take           (take),
        .out            (out)
    );

endmodule

`default_nettype wire

// File: sim/ctpd_pixel_checker.sv
`timescale 1ns / 1ps

module ctpd_pixel_checker
    import ctpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ctpd_in_if         in_ch,
    ctpd_out_if        out_ch,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [1:0] cfg_data,
    output int         errors,
    output int         pending,
    output int         checked
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } pixel_beat_t;

    pixel_beat_t pixel_q[$];
    pixel_beat_t want;
    logic [31:0] palette_img [CTPD_PALETTE_DEPTH];
    logic [1:0]  mode_q;
    logic [1:0]  fmt_q;

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH %s", $time, what);
        errors++;
    endtask

    function automatic logic [7:0] widen5(logic [4:0] c);
        int unsigned v;
        v = (int'(c) * 255) / 31;
        return v[7:0];
    endfunction

    // Packed RGBA, red in the low byte
    function automatic logic [31:0] lookup_rgba(logic [7:0] idx, logic [31:0] pixel);
        logic [31:0] e;
        e = palette_img[idx];
        case (fmt_q)
            FMT_NONE:   return pixel;
            FMT_A1BGR5: return {e[15] ? 8'hFF : 8'h00, widen5(e[14:10]), widen5(e[9:5]),
                                widen5(e[4:0])};
            FMT_XBGR8:  return {8'hFF, e[23:0]};
            default:    return e;
        endcase
    endfunction

    function automatic void queue_pixel(logic [31:0] rgba, logic last);
        pixel_q.push_back('{rgba[7:0], rgba[15:8], rgba[23:16], rgba[31:24], last});
    endfunction

    function automatic void predict_pixels(logic [31:0] pixel);
        logic [7:0] b;
        b = pixel[7:0];
        case (mode_q)
            MODE_NIBBLE:
            begin
                queue_pixel(lookup_rgba({4'h0, b[3:0]}, pixel), 1'b0);
                queue_pixel(lookup_rgba({4'h0, b[7:4]}, pixel), 1'b1);
            end
            MODE_SWIZZLE: queue_pixel(lookup_rgba({b[7:5], b[3], b[4], b[2:0]}, pixel), 1'b1);
            default:      queue_pixel(lookup_rgba(b, pixel), 1'b1);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q  = INDEX_MODE_RESET;
            fmt_q   = PALETTE_FORMAT_RESET;
            pixel_q.delete();
            errors  = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_we === 1'b1)
            begin
                if (cfg_index == CFG_INDEX_MODE)
                    mode_q = cfg_data;
                else
                    fmt_q = cfg_data;
            end

            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (pixel_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat rgba=%h%h%h%h last=%b",
                        out_ch.alpha, out_ch.blue, out_ch.green, out_ch.red, out_ch.last));
                end
                else
                begin
                    want = pixel_q.pop_front();
                    checked++;
                    if (out_ch.red !== want.red)
                        report_mismatch($sformatf("red %h, want %h", out_ch.red, want.red));
                    if (out_ch.green !== want.green)
                        report_mismatch($sformatf("green %h, want %h", out_ch.green,
                            want.green));
                    if (out_ch.blue !== want.blue)
                        report_mismatch($sformatf("blue %h, want %h", out_ch.blue, want.blue));
                    if (out_ch.alpha !== want.alpha)
                        report_mismatch($sformatf("alpha %h, want %h", out_ch.alpha,
                            want.alpha));
                    if (out_ch.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", out_ch.last, want.last));
                end
            end

            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            begin
                if (in_ch.command == CMD_WRITE)
                    palette_img[in_ch.palette_index] = in_ch.palette_word;
                else
                    predict_pixels(in_ch.pixel_word);
            end

            pending = pixel_q.size();
        end
    end

endmodule

// File: sim/tb_clut_texture_pixel_decode.sv
`timescale 1ns / 1ps

module tb_clut_texture_pixel_decode;
    import ctpd_pkg::*;

    // index mode 3 decodes like direct mode
    localparam logic [1:0] MODE_DIRECT_ALIAS = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int RUN_LIMIT_NS  = 4_000_000;
    localparam int PHASE_ITEMS   = 32;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [1:0] cfg_data;

    int errors;
    int pending;
    int checked;
    int n_writes;
    int n_decodes;
    int waited;
    int total;

    bit         written [CTPD_PALETTE_DEPTH];
    logic [1:0] cur_mode;
    logic [1:0] cur_fmt;
    bit         gaps_on;

    ctpd_in_if  in_ch();
    ctpd_out_if out_ch();

    clut_texture_pixel_decode dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ctpd_pixel_checker check_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Output side: random backpressure while gaps_on is set
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ch.ready <= !(gaps_on && $urandom_range(99) < 17);
        end
    end

    task automatic send_beat(logic cmd, logic [7:0] idx, logic [31:0] word,
                             logic [31:0] pixel);
        while (gaps_on && $urandom_range(99) < 17)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.palette_index <= idx;
        in_ch.palette_word  <= word;
        in_ch.pixel_word    <= pixel;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        if (cmd == CMD_WRITE)
            n_writes++;
        else
            n_decodes++;
    endtask

    task automatic push_write(logic [7:0] idx, logic [31:0] word);
        written[idx] = 1'b1;
        send_beat(CMD_WRITE, idx, word, $urandom);
    endtask

    task automatic push_pixel(logic [31:0] pixel);
        send_beat(CMD_DECODE, 8'($urandom), $urandom, pixel);
    endtask

    // Drop valid and hold until every expected beat has come back
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_reg(logic index, logic [1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_INDEX_MODE)
            cur_mode = value;
        else
            cur_fmt = value;
    endtask

    // Palette entry a decode of this byte would read and that is still unwritten
    function automatic int missing_entry(logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        if (cur_fmt == FMT_NONE)
            return -1;
        case (cur_mode)
            MODE_NIBBLE:
            begin
                lo = {4'h0, b[3:0]};
                hi = {4'h0, b[7:4]};
                if (!written[lo])
                    return int'(lo);
                if (!written[hi])
                    return int'(hi);
                return -1;
            end
            MODE_SWIZZLE: lo = {b[7:5], b[3], b[4], b[2:0]};
            default:      lo = b;
        endcase
        return written[lo] ? -1 : int'(lo);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom | 32'h0000_8000;
            3:       return $urandom & 32'hFFFF_7FFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        logic [31:0] pixel;
        int miss;
        int tries;
        if ($urandom_range(99) < 25)
        begin
            push_write(8'($urandom_range(255)), pick_word());
            return;
        end
        miss  = 1;
        tries = 0;
        while (miss >= 0 && tries < 8)
        begin
            pixel = $urandom;
            miss  = missing_entry(pixel[7:0]);
            tries++;
        end
        // fill the entry first when no readable byte turned up
        if (miss < 0)
            push_pixel(pixel);
        else
            push_write(miss[7:0], pick_word());
    endtask

    task automatic directed_items();
        // reset settings: swizzled index, ABGR8
        push_write(8'h00, 32'h0000_0000);
        push_write(8'hFF, 32'hFFFF_FFFF);
        push_write(8'h08, 32'h1122_3344);
        push_write(8'h10, 32'h8000_7FFF);
        push_write(8'h0F, 32'h0000_8000);
        push_pixel(32'h0000_0008);
        push_pixel(32'hAABB_CC10);
        push_pixel(32'h0000_00FF);
        push_pixel(32'h0000_0000);

        set_reg(CFG_PALETTE_FORMAT, FMT_A1BGR5);
        push_pixel(32'h0000_0008);
        set_reg(CFG_INDEX_MODE, MODE_DIRECT);
        push_pixel(32'h0000_000F);
        push_pixel(32'h0000_00FF);

        set_reg(CFG_PALETTE_FORMAT, FMT_XBGR8);
        push_pixel(32'h0000_0008);
        push_pixel(32'h0000_0000);

        set_reg(CFG_INDEX_MODE, MODE_NIBBLE);
        push_pixel(32'h5A5A_A5F0);
        push_pixel(32'hA5A5_5A0F);

        // format none passes the word through, both nibble pixels alike
        set_reg(CFG_PALETTE_FORMAT, FMT_NONE);
        push_pixel(32'hDEAD_BEEF);
        push_pixel(32'h1234_5678);

        set_reg(CFG_INDEX_MODE, MODE_DIRECT_ALIAS);
        set_reg(CFG_PALETTE_FORMAT, FMT_ABGR8);
        push_pixel(32'h0000_00FF);
        push_pixel(32'h0000_0008);
        set_reg(CFG_PALETTE_FORMAT, FMT_NONE);
        push_pixel(32'hFFFF_FFFF);

        set_reg(CFG_INDEX_MODE, MODE_SWIZZLE);
        push_pixel(32'h0000_0000);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_INDEX_MODE;
        cfg_data            = 2'b00;
        in_ch.valid         = 1'b0;
        in_ch.command       = CMD_WRITE;
        in_ch.palette_index = 8'h00;
        in_ch.palette_word  = 32'h0;
        in_ch.pixel_word    = 32'h0;
        cur_mode            = INDEX_MODE_RESET;
        cur_fmt             = PALETTE_FORMAT_RESET;
        gaps_on             = 1'b1;
        n_writes            = 0;
        n_decodes           = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_items();

        // every mode/format pair, with a stretch of phases at full rate
        for (int p = 0; p < 16; p++)
        begin
            set_reg(CFG_INDEX_MODE, 2'(p % 4));
            set_reg(CFG_PALETTE_FORMAT, 2'(p / 4));
            gaps_on = (p < 6 || p > 9);
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_item();
        end

        gaps_on = 1'b1;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        total = errors;
        if (pending != 0)
        begin
            $display("%0d expected beats never arrived", pending);
            total = total + pending;
        end
        $display("Sent %0d palette writes and %0d decode beats over all 16 mode/format pairs.",
            n_writes, n_decodes);
        $display("Compared %0d output beats, %0d mismatches.", checked, errors);
        if (total == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: clut_texture_pixel_decode.f
+incdir+hdl
hdl/ctpd_pkg.sv
hdl/ctpd_if.sv
hdl/ctpd_issue.sv
hdl/ctpd_palette.sv
hdl/ctpd_expand.sv
hdl/clut_texture_pixel_decode.sv
sim/ctpd_pixel_checker.sv
sim/tb_clut_texture_pixel_decode.sv
